FILE: src/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

   localparam int MaxResults = 4;
   localparam int CountWidth = $clog2(MaxResults + 1);
   localparam int IndexWidth = $clog2(MaxResults);

   localparam logic [1:0] MODE_TEXT = 2'd0;
   localparam logic [1:0] MODE_ESC  = 2'd1;
   localparam logic [1:0] MODE_HEX  = 2'd2;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_ESCAPE = 2'd1;
   localparam logic [1:0] ERR_HEX    = 2'd2;
   localparam logic [1:0] ERR_END    = 2'd3;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;

   localparam logic [7:0] CTRL_BS = 8'h08;
   localparam logic [7:0] CTRL_FF = 8'h0C;
   localparam logic [7:0] CTRL_LF = 8'h0A;
   localparam logic [7:0] CTRL_CR = 8'h0D;
   localparam logic [7:0] CTRL_HT = 8'h09;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] acc;
      logic [1:0]  cnt;
   } state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] err;
   } result_type;

   typedef struct packed {
      result_type [MaxResults-1:0] item;
      logic [CountWidth-1:0]       count;
   } burst_type;

   // valid flag on top, digit value below
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/jsu_decode.sv
`default_nettype none
module jsu_decode (
   input  jsu_pkg::state_type state_cur,
   input  logic [7:0]         in_byte,
   input  logic               end_of_input,
   output jsu_pkg::state_type state_nxt,
   output jsu_pkg::burst_type burst
);
   import jsu_pkg::*;

   logic [4:0]  hexv;
   logic [15:0] acc_new;
   logic [7:0]  u0, u1, u2;
   logic [1:0]  ucount;
   logic [7:0]  esc_val;
   logic        esc_simple;

   assign hexv    = hex_digit(in_byte);
   assign acc_new = {state_cur.acc[11:0], hexv[3:0] & {4{hexv[4]}}};

   always_comb begin
      u0 = 8'd0;
      u1 = 8'd0;
      u2 = 8'd0;
      if (acc_new[15:7] == 9'd0) begin
         u0     = {1'b0, acc_new[6:0]};
         ucount = 2'd1;
      end else if (acc_new[15:11] == 5'd0) begin
         u0     = {3'b110, acc_new[10:6]};
         u1     = {2'b10, acc_new[5:0]};
         ucount = 2'd2;
      end else begin
         u0     = {4'b1110, acc_new[15:12]};
         u1     = {2'b10, acc_new[11:6]};
         u2     = {2'b10, acc_new[5:0]};
         ucount = 2'd3;
      end
   end

   always_comb begin
      esc_simple = 1'b1;
      case (in_byte)
         CHAR_QUOTE:     esc_val = CHAR_QUOTE;
         CHAR_BACKSLASH: esc_val = CHAR_BACKSLASH;
         CHAR_SLASH:     esc_val = CHAR_SLASH;
         CHAR_B:         esc_val = CTRL_BS;
         CHAR_F:         esc_val = CTRL_FF;
         CHAR_N:         esc_val = CTRL_LF;
         CHAR_R:         esc_val = CTRL_CR;
         CHAR_T:         esc_val = CTRL_HT;
         default: begin
            esc_val    = 8'd0;
            esc_simple = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_nxt = state_cur;
      burst     = '0;
      if (end_of_input) begin
         burst.item[0] = '{kind: KIND_ERROR, data: 8'd0, err: ERR_END};
         burst.count   = CountWidth'(1);
         state_nxt     = '{mode: MODE_TEXT, acc: 16'd0, cnt: 2'd0};
      end else if (state_cur.mode == MODE_ESC) begin
         if (esc_simple) begin
            burst.item[0] = '{kind: KIND_DATA, data: esc_val, err: ERR_NONE};
            burst.count   = CountWidth'(1);
            state_nxt     = '{mode: MODE_TEXT, acc: 16'd0, cnt: 2'd0};
         end else if (in_byte == CHAR_U) begin
            state_nxt = '{mode: MODE_HEX, acc: 16'd0, cnt: 2'd0};
         end else begin
            burst.item[0] = '{kind: KIND_ERROR, data: 8'd0, err: ERR_ESCAPE};
            burst.count   = CountWidth'(1);
            state_nxt     = '{mode: MODE_TEXT, acc: 16'd0, cnt: 2'd0};
         end
      end else if (state_cur.mode == MODE_HEX) begin
         if (state_cur.cnt == 2'd3) begin
            if (!hexv[4]) begin
               burst.item[0] = '{kind: KIND_ERROR, data: 8'd0, err: ERR_HEX};
               burst.item[1] = '{kind: KIND_DATA, data: u0, err: ERR_NONE};
               burst.item[2] = '{kind: KIND_DATA, data: u1, err: ERR_NONE};
               burst.item[3] = '{kind: KIND_DATA, data: u2, err: ERR_NONE};
               burst.count   = CountWidth'(ucount) + CountWidth'(1);
            end else begin
               burst.item[0] = '{kind: KIND_DATA, data: u0, err: ERR_NONE};
               burst.item[1] = '{kind: KIND_DATA, data: u1, err: ERR_NONE};
               burst.item[2] = '{kind: KIND_DATA, data: u2, err: ERR_NONE};
               burst.count   = CountWidth'(ucount);
            end
            state_nxt = '{mode: MODE_TEXT, acc: 16'd0, cnt: 2'd0};
         end else begin
            if (!hexv[4]) begin
               burst.item[0] = '{kind: KIND_ERROR, data: 8'd0, err: ERR_HEX};
               burst.count   = CountWidth'(1);
            end
            state_nxt.acc = acc_new;
            state_nxt.cnt = state_cur.cnt + 2'd1;
         end
      end else begin
         if (in_byte == CHAR_BACKSLASH) begin
            state_nxt.mode = MODE_ESC;
         end else if (in_byte == CHAR_QUOTE) begin
            burst.item[0] = '{kind: KIND_DONE, data: 8'd0, err: ERR_NONE};
            burst.count   = CountWidth'(1);
            state_nxt     = '{mode: MODE_TEXT, acc: 16'd0, cnt: 2'd0};
         end else begin
            burst.item[0]  = '{kind: KIND_DATA, data: in_byte, err: ERR_NONE};
            burst.count    = CountWidth'(1);
            state_nxt.mode = MODE_TEXT;
         end
      end
   end

endmodule
`default_nettype wire

FILE: src/json_string_unescaper_core.sv
// JSON string body decoder.
// Request channel (req_valid/req_stall) carries one string-body byte per word,
// starting after the opening quote, or an end-of-input marker.
// Response channel (rsp_valid/rsp_stall) carries decoded words: data bytes,
// error reports and string-finished marks; rsp_last flags the final response
// word caused by one request word.
// Each accepted request is decoded in its accept cycle; its zero to four
// response words land in a burst register and appear from the next cycle on,
// one word per cycle while the receiver does not stall.
// Throughput: one request word per cycle while each request yields at most one
// response word and rsp_stall is low; N words from one request hold the
// response side until all have left. The burst register is the limit: a new
// request is taken in the cycle the last word of a burst leaves, or when empty.
// Requests that yield no response (backslash, \u, first three valid hex digits)
// leave the burst register empty and show nothing.
// Reset empties the burst register and returns the parser to text mode.
// While rsp_stall is high the current response word holds and req_stall rises
// once a burst is pending.
`default_nettype none
module json_string_unescaper_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last
);
   import jsu_pkg::*;

   state_type                    state_ff, state_in, state_dec;
   burst_type                    burst_dec;
   result_type [MaxResults-1:0]  item_ff;
   logic [CountWidth-1:0]        count_ff, count_in;
   logic [IndexWidth-1:0]        idx_ff, idx_in;
   logic                         req_fire, rsp_fire, idx_at_end, drain_last;
   result_type                   cur;

   jsu_decode u_decode (
      .state_cur    (state_ff),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .state_nxt    (state_dec),
      .burst        (burst_dec)
   );

   assign rsp_valid  = (count_ff != '0);
   assign idx_at_end = ({1'b0, idx_ff} == count_ff - CountWidth'(1));
   assign rsp_fire   = rsp_valid && !rsp_stall;
   assign drain_last = rsp_fire && idx_at_end;
   assign req_stall  = rsp_valid && !drain_last;
   assign req_fire   = req_valid && !req_stall;

   assign cur            = item_ff[idx_ff];
   assign rsp_kind       = cur.kind;
   assign rsp_out_byte   = cur.data;
   assign rsp_error_code = cur.err;
   assign rsp_last       = idx_at_end;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      if (req_fire) begin
         state_in = state_dec;
         count_in = burst_dec.count;
         idx_in   = '0;
      end else if (drain_last) begin
         count_in = '0;
         idx_in   = '0;
      end else if (rsp_fire) begin
         idx_in = idx_ff + IndexWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_TEXT, acc: 16'd0, cnt: 2'd0};
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= burst_dec.item;
      end
   end

   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, idx_ff} < count_ff))
      else $error("response index beyond burst");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response pending after reset");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode != 2'd3)
      else $error("unused parser mode reached");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_last) |=> rsp_valid)
      else $error("burst cut short");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while response held");

endmodule
`default_nettype wire

FILE: bench/tb_json_string_unescaper_core.sv
`default_nettype none
module tb_json_string_unescaper_core;
   import jsu_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int ReportLimit = 10;

   localparam logic [7:0] SIMPLE_ESC [8] = '{CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH,
      CHAR_B, CHAR_F, CHAR_N, CHAR_R, CHAR_T};
   localparam logic [7:0] HEX_EDGES [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

   typedef struct packed {
      logic [7:0] in_byte;
      logic       eoi;
   } body_word_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] code;
      logic       last;
   } decoded_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_error_code;
   logic       rsp_last;

   body_word_type    body_bytes[$];
   decoded_word_type decoded_due[$];

   logic        req_took = 1'b0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          queued = 0;
   int          mismatches = 0;
   int          cycle_count = 0;

   logic [1:0]  dec_mode = MODE_TEXT;
   logic [15:0] dec_acc = 16'h0000;
   logic [1:0]  dec_cnt = 2'd0;

   json_string_unescaper_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void add_word(input logic [1:0] kind, input logic [7:0] data,
                                    input logic [1:0] code);
      decoded_word_type w;
      w.kind = kind;
      w.data = data;
      w.code = code;
      w.last = 1'b0;
      decoded_due.push_back(w);
   endfunction

   function automatic void clear_decoder();
      dec_mode = MODE_TEXT;
      dec_acc = 16'h0000;
      dec_cnt = 2'd0;
   endfunction

   function automatic void unescape_byte(input logic [7:0] c, input logic eoi);
      int               base;
      logic             simple;
      logic             good;
      logic [7:0]       ctrl;
      logic [3:0]       digit;
      logic [15:0]      cp;
      decoded_word_type w;
      base = decoded_due.size();
      if (eoi) begin
         add_word(KIND_ERROR, 8'h00, ERR_END);
         clear_decoder();
      end else if (dec_mode == MODE_ESC) begin
         simple = 1'b1;
         ctrl = c;
         case (c)
            CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: ctrl = c;
            CHAR_B: ctrl = CTRL_BS;
            CHAR_F: ctrl = CTRL_FF;
            CHAR_N: ctrl = CTRL_LF;
            CHAR_R: ctrl = CTRL_CR;
            CHAR_T: ctrl = CTRL_HT;
            default: simple = 1'b0;
         endcase
         if (simple) begin
            add_word(KIND_DATA, ctrl, ERR_NONE);
            clear_decoder();
         end else if (c == CHAR_U) begin
            dec_mode = MODE_HEX;
            dec_acc = 16'h0000;
            dec_cnt = 2'd0;
         end else begin
            add_word(KIND_ERROR, 8'h00, ERR_ESCAPE);
            clear_decoder();
         end
      end else if (dec_mode == MODE_HEX) begin
         good = 1'b1;
         digit = 4'h0;
         if (c >= 8'h30 && c <= 8'h39) begin
            digit = c[3:0];
         end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            digit = c[3:0] + 4'd9;
         end else begin
            good = 1'b0;
         end
         if (!good) begin
            add_word(KIND_ERROR, 8'h00, ERR_HEX);
         end
         dec_acc = {dec_acc[11:0], digit};
         if (dec_cnt == 2'd3) begin
            cp = dec_acc;
            if (cp < 16'h0080) begin
               add_word(KIND_DATA, cp[7:0], ERR_NONE);
            end else if (cp < 16'h0800) begin
               add_word(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE);
               add_word(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
            end else begin
               add_word(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE);
               add_word(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
               add_word(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
            end
            clear_decoder();
         end else begin
            dec_cnt = dec_cnt + 2'd1;
         end
      end else begin
         if (c == CHAR_BACKSLASH) begin
            dec_mode = MODE_ESC;
         end else if (c == CHAR_QUOTE) begin
            add_word(KIND_DONE, 8'h00, ERR_NONE);
            clear_decoder();
         end else begin
            add_word(KIND_DATA, c, ERR_NONE);
            dec_mode = MODE_TEXT;
         end
      end
      if (decoded_due.size() > base) begin
         w = decoded_due.pop_back();
         w.last = 1'b1;
         decoded_due.push_back(w);
      end
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
      if (v < 4'd10) begin
         return 8'h30 + 8'(v);
      end
      return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   function automatic void queue_byte(input logic [7:0] b, input logic eoi);
      body_word_type w;
      w.in_byte = b;
      w.eoi = eoi;
      body_bytes.push_back(w);
      queued++;
   endfunction

   task automatic run_phase(input int send_idle, input int stall, input int count);
      int          stop;
      int          pick;
      int          n;
      logic [15:0] cp;
      logic [7:0]  esc;
      logic [7:0]  bad;
      stop = queued + count;
      send_idle_pct = send_idle;
      stall_pct = stall;
      while (queued < stop) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            queue_byte(8'($urandom_range(255)), 1'b0);
         end else if (pick < 48) begin
            queue_byte(CHAR_BACKSLASH, 1'b0);
            queue_byte(SIMPLE_ESC[$urandom_range(7)], 1'b0);
         end else if (pick < 73) begin
            queue_byte(CHAR_BACKSLASH, 1'b0);
            queue_byte(CHAR_U, 1'b0);
            case ($urandom_range(2))
               0: cp = 16'($urandom_range(16'h007F));
               1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
               default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
            endcase
            for (int i = 3; i >= 0; i--) begin
               if ($urandom_range(9) == 0) begin
                  case ($urandom_range(3))
                     0: bad = CHAR_QUOTE;
                     1: bad = CHAR_BACKSLASH;
                     2: bad = HEX_EDGES[$urandom_range(5)];
                     default: bad = 8'($urandom_range(255));
                  endcase
                  queue_byte(bad, 1'b0);
               end else begin
                  queue_byte(hex_char(cp[4*i +: 4], 1'($urandom_range(1))), 1'b0);
               end
            end
         end else if (pick < 83) begin
            queue_byte(CHAR_QUOTE, 1'b0);
         end else if (pick < 89) begin
            do begin
               esc = 8'($urandom_range(255));
            end while (esc == CHAR_U || esc == CHAR_QUOTE || esc == CHAR_BACKSLASH ||
                       esc == CHAR_SLASH || esc == CHAR_B || esc == CHAR_F ||
                       esc == CHAR_N || esc == CHAR_R || esc == CHAR_T);
            queue_byte(CHAR_BACKSLASH, 1'b0);
            queue_byte(esc, 1'b0);
         end else if (pick < 95) begin
            queue_byte(CHAR_BACKSLASH, 1'b0);
            if ($urandom_range(1) == 1) begin
               queue_byte(CHAR_U, 1'b0);
               n = $urandom_range(3);
               repeat (n) queue_byte(hex_char(4'($urandom_range(15)),
                                              1'($urandom_range(1))), 1'b0);
            end
            queue_byte(8'($urandom_range(255)), 1'b1);
         end else begin
            queue_byte(8'($urandom_range(255)), 1'b1);
         end
      end
      while (body_bytes.size() != 0 || req_valid || decoded_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(negedge clock) begin : drive_req
      body_word_type nxt;
      if (!reset && (!req_valid || req_took)) begin
         if (body_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = body_bytes.pop_front();
            req_valid <= 1'b1;
            req_in_byte <= nxt.in_byte;
            req_end_of_input <= nxt.eoi;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : watch_rsp
      decoded_word_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            unescape_byte(req_in_byte, req_end_of_input);
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_due.size() == 0) begin
               mismatches++;
               if (mismatches <= ReportLimit) begin
                  $display("tb: unexpected word kind=%0d byte=%02h code=%0d last=%0b",
                           rsp_kind, rsp_out_byte, rsp_error_code, rsp_last);
               end
            end else begin
               want = decoded_due.pop_front();
               if (rsp_kind !== want.kind || rsp_out_byte !== want.data ||
                   rsp_error_code !== want.code || rsp_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= ReportLimit) begin
                     $display("tb: mismatch expected kind=%0d byte=%02h code=%0d last=%0b",
                              want.kind, want.data, want.code, want.last);
                     $display("tb:          actual   kind=%0d byte=%02h code=%0d last=%0b",
                              rsp_kind, rsp_out_byte, rsp_error_code, rsp_last);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(CHAR_BACKSLASH, 1'b0);
      queue_byte(CHAR_N, 1'b0);
      queue_byte(CHAR_BACKSLASH, 1'b0);
      queue_byte(8'h71, 1'b0);
      queue_byte(CHAR_BACKSLASH, 1'b0);
      queue_byte(CHAR_U, 1'b0);
      queue_byte(8'h46, 1'b0);
      queue_byte(8'h66, 1'b0);
      queue_byte(8'h46, 1'b0);
      queue_byte(8'h66, 1'b0);
      queue_byte(CHAR_BACKSLASH, 1'b0);
      queue_byte(CHAR_U, 1'b0);
      queue_byte(8'h30, 1'b0);
      queue_byte(8'h30, 1'b0);
      queue_byte(8'h67, 1'b0);
      queue_byte(CHAR_QUOTE, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(CHAR_BACKSLASH, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(CHAR_QUOTE, 1'b0);

      run_phase(0, 0, 45);
      run_phase(56, 0, 62);
      run_phase(0, 56, 62);
      run_phase(19, 19, 62);

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
